FILE: design/rgb_level_command_parser_defines.svh
// Assertion macros for the RGB level command parser.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef RGB_LEVEL_COMMAND_PARSER_DEFINES_SVH
`define RGB_LEVEL_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define RGBL_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rgbl assertion failed");

`define RGBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbl assertion failed");

`else

`define RGBL_ASSERT_NOW(label, cond)

`define RGBL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/rgbl_pkg.sv
// Shared types and constants for the RGB level command parser.
// No dependencies; used by rgbl_decode, rgbl_parse and the top level.
package rgbl_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned NIBBLE_W = 4;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [NIBBLE_W-1:0] LETTER_OFFSET = 4'd9;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'h00;

  typedef enum logic [1:0] {
    POS_IDLE   = 2'd0,
    POS_FIRST  = 2'd1,
    POS_SECOND = 2'd2
  } pos_t;

  typedef enum logic [1:0] {
    COLOR_RED   = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_BLUE  = 2'd2
  } color_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RED,
    CMD_GREEN,
    CMD_BLUE,
    CMD_REPORT,
    CMD_WHITE,
    CMD_OFF,
    CMD_START
  } cmd_t;

  typedef struct packed {
    logic                is_hex;
    logic [NIBBLE_W-1:0] hex_val;
    cmd_t                cmd;
  } class_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               updated;
    logic               report;
    color_t             color;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

FILE: design/rgbl_decode.sv
// Character classifier: hex digit value and idle command letter of one byte.
// Depends on rgbl_pkg.
module rgbl_decode (
  input  logic [7:0]      rx_byte,
  output rgbl_pkg::class_t cls
);
  import rgbl_pkg::*;

  always_comb begin
    cls.is_hex  = 1'b1;
    cls.hex_val = rx_byte[NIBBLE_W-1:0];
    case (rx_byte) inside
      [CHAR_ZERO:CHAR_NINE]: cls.hex_val = rx_byte[NIBBLE_W-1:0];
      [CHAR_UPPER_A:CHAR_UPPER_F],
      [CHAR_LOWER_A:CHAR_LOWER_F]: cls.hex_val = rx_byte[NIBBLE_W-1:0] + LETTER_OFFSET;
      default: begin
        cls.is_hex  = 1'b0;
        cls.hex_val = '0;
      end
    endcase

    case (rx_byte) inside
      "r", "R": cls.cmd = CMD_RED;
      "g", "G": cls.cmd = CMD_GREEN;
      "b", "B": cls.cmd = CMD_BLUE;
      "p", "P": cls.cmd = CMD_REPORT;
      "w", "W": cls.cmd = CMD_WHITE;
      "o", "O": cls.cmd = CMD_OFF;
      "c", "C": cls.cmd = CMD_START;
      default:  cls.cmd = CMD_NONE;
    endcase
  end

endmodule

FILE: design/rgbl_parse.sv
// Parser state (position, color, levels, pending nibble) and its update per item.
// Depends on rgbl_pkg; fed by rgbl_decode.
module rgbl_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rgbl_pkg::class_t  cls,
  output rgbl_pkg::result_t res,
  output rgbl_pkg::pos_t    pos
);
  import rgbl_pkg::*;

  color_t              color, color_next;
  pos_t                pos_next;
  logic [LEVEL_W-1:0]  red, red_next;
  logic [LEVEL_W-1:0]  green, green_next;
  logic [LEVEL_W-1:0]  blue, blue_next;
  logic [NIBBLE_W-1:0] nibble, nibble_next;
  logic [LEVEL_W-1:0]  cmd_value;

  assign cmd_value = {nibble, cls.hex_val};

  always_comb begin
    pos_next    = POS_IDLE;
    color_next  = color;
    red_next    = red;
    green_next  = green;
    blue_next   = blue;
    nibble_next = nibble;
    res.updated = 1'b0;
    res.report  = 1'b0;
    res.color   = COLOR_RED;
    res.level   = LEVEL_OFF;

    case (pos)
      POS_FIRST: begin
        if (cls.is_hex) begin
          nibble_next = cls.hex_val;
          pos_next    = POS_SECOND;
        end else begin
          nibble_next = '0;
        end
      end
      POS_SECOND: begin
        nibble_next = '0;
        if (cls.is_hex) begin
          res.updated = 1'b1;
          case (color)
            COLOR_GREEN: green_next = cmd_value;
            COLOR_BLUE:  blue_next  = cmd_value;
            default:     red_next   = cmd_value;
          endcase
        end
      end
      default: begin
        case (cls.cmd)
          CMD_RED:   color_next = COLOR_RED;
          CMD_GREEN: color_next = COLOR_GREEN;
          CMD_BLUE:  color_next = COLOR_BLUE;
          CMD_REPORT: begin
            res.report = 1'b1;
            case (color)
              COLOR_GREEN: begin
                res.color = COLOR_GREEN;
                res.level = green;
              end
              COLOR_BLUE: begin
                res.color = COLOR_BLUE;
                res.level = blue;
              end
              default: begin
                res.color = COLOR_RED;
                res.level = red;
              end
            endcase
          end
          CMD_WHITE: begin
            red_next    = LEVEL_FULL;
            green_next  = LEVEL_FULL;
            blue_next   = LEVEL_FULL;
            res.updated = 1'b1;
          end
          CMD_OFF: begin
            red_next    = LEVEL_OFF;
            green_next  = LEVEL_OFF;
            blue_next   = LEVEL_OFF;
            res.updated = 1'b1;
          end
          CMD_START: pos_next = POS_FIRST;
          default:   pos_next = POS_IDLE;
        endcase
      end
    endcase

    res.red   = red_next;
    res.green = green_next;
    res.blue  = blue_next;
  end

  // Commit the new state only when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= POS_IDLE;
      color  <= COLOR_RED;
      red    <= LEVEL_OFF;
      green  <= LEVEL_OFF;
      blue   <= LEVEL_OFF;
      nibble <= '0;
    end else if (advance) begin
      pos    <= pos_next;
      color  <= color_next;
      red    <= red_next;
      green  <= green_next;
      blue   <= blue_next;
      nibble <= nibble_next;
    end
  end

endmodule

FILE: design/rgb_level_command_parser.sv
// Top level of the RGB level command parser: input register, decode, parse, result register.
// Depends on rgbl_pkg, rgbl_decode, rgbl_parse and rgb_level_command_parser_defines.svh.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    rx_byte
//  out      out_valid / out_ready  red_level green_level blue_level levels_updated
//                                  report_valid report_color report_level
//
// An accepted item sits in the input register while decode and parse form the next value of
// the result register. One item per cycle is sustained while the result is not stalled;
// the state commits as the item enters the result register.
// Reset clears both register valids and the parser state (idle, red, all levels zero).
// A stalled result holds the result register; the input register still takes one more item.
`include "rgb_level_command_parser_defines.svh"

module rgb_level_command_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red_level,
  output logic [7:0] green_level,
  output logic [7:0] blue_level,
  output logic       levels_updated,
  output logic       report_valid,
  output logic [1:0] report_color,
  output logic [7:0] report_level
);
  import rgbl_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       advance;
  class_t     cls;
  result_t    res;
  result_t    res_q;
  pos_t       pos;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
    end
  end

  rgbl_decode u_decode (
    .rx_byte (in_q_byte),
    .cls     (cls)
  );

  rgbl_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cls     (cls),
    .res     (res),
    .pos     (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign red_level      = res_q.red;
  assign green_level    = res_q.green;
  assign blue_level     = res_q.blue;
  assign levels_updated = res_q.updated;
  assign report_valid   = res_q.report;
  assign report_color   = res_q.color;
  assign report_level   = res_q.level;

  // A waiting input item is never dropped before it reaches the result register.
  `RGBL_ASSERT_NEXT(a_input_held, in_q_valid && !advance, in_q_valid)
  // Report fields are zero whenever no report was requested.
  `RGBL_ASSERT_NOW(a_no_report_zero,
    !(out_valid && !report_valid) || (report_color == 2'd0 && report_level == 8'd0))
  // A report and a level update never come from the same item.
  `RGBL_ASSERT_NOW(a_report_or_update, !(out_valid && report_valid && levels_updated))
  // The parse position holds whenever no item advances.
  `RGBL_ASSERT_NEXT(a_pos_from_advance, !advance, $stable(pos))

endmodule
